@@ hdl/fir_pkg.sv @@
// Package for the 32-tap FIR filter: sizes, fixed-point constants and the
// item record that travels down the tap chain. No dependencies.
package fir_pkg;

   localparam int TAPS      = 32;
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 18;
   localparam int IDX_W     = 5;
   localparam int FRAC_W    = COEF_W - 2;
   localparam int ACC_W     = SAMPLE_W + COEF_W + $clog2(TAPS);

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_W - 1);
   localparam logic signed [ACC_W-1:0] OUT_MAX    = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] OUT_MIN    = -(ACC_W'(1) <<< (SAMPLE_W - 1));

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_COEF   = 1'b1;

   typedef struct packed {
      logic                       vld;
      logic                       mode;
      logic                       blk;
      logic [IDX_W-1:0]           idx;
      logic signed [COEF_W-1:0]   coef;
      logic signed [SAMPLE_W-1:0] smp;
      logic signed [ACC_W-1:0]    acc;
   } item_type;

endpackage

@@ hdl/fir_filter_32_tap.sv @@
// Top level of the 32-tap systolic FIR filter: a chain of fir_cell taps and
// the fir_round output stage. Depends on fir_pkg, fir_cell, fir_round.
//
//   port group  direction  transaction
//   req_*       in         sample (mode 0) or coefficient load (mode 1)
//   rsp_*       out        one filtered sample per sample transaction
//
// One transaction per clock unless the chain stalls; an accepted sample's
// sum passes the output register of every tap, then the rounding register.
// Reset clears taps, history and all valid bits at once; no clearing pass.
// The chain stalls only when its last tap holds a result and the output
// register is full and not taken; bubbles and coefficient loads never stall.
module fir_filter_32_tap (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic                                req_block_start,
   input  logic signed [fir_pkg::SAMPLE_W-1:0] req_sample,
   input  logic [fir_pkg::IDX_W-1:0]           req_coef_index,
   input  logic signed [fir_pkg::COEF_W-1:0]   req_coef_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fir_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                                rsp_saturated
);
   import fir_pkg::*;

   item_type head;
   item_type stage [TAPS];
   item_type tail;
   logic     adv;
   logic     tail_result;
   logic     rnd_ready;

   always_comb begin
      head.vld  = req_valid;
      head.mode = req_mode;
      head.blk  = req_block_start;
      head.idx  = req_coef_index;
      head.coef = req_coef_value;
      head.smp  = req_sample;
      head.acc  = '0;
   end

   assign tail        = stage[TAPS-1];
   assign tail_result = tail.vld && (tail.mode == MODE_SAMPLE);
   assign adv         = !tail_result || rnd_ready;
   assign req_ready   = adv;

   for (genvar j = 0; j < TAPS; j++) begin : g_tap
      if (j == 0) begin : g_first
         fir_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .adv      (adv),
            .cell_idx (IDX_W'(j)),
            .in_item  (head),
            .out_item (stage[j])
         );
      end else begin : g_rest
         fir_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .adv      (adv),
            .cell_idx (IDX_W'(j)),
            .in_item  (stage[j-1]),
            .out_item (stage[j])
         );
      end
   end

   fir_round u_round (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (tail_result),
      .in_ready      (rnd_ready),
      .in_acc        (tail.acc),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_filtered  (rsp_filtered),
      .rsp_saturated (rsp_saturated)
   );

`ifndef SYNTHESIS
   a_ready_without_tail_result: assert property (@(posedge clock)
      !tail_result |-> req_ready)
      else $error("input stalled although the chain tail holds no result");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

@@ hdl/fir_cell.sv @@
// One tap of the systolic FIR chain: holds one coefficient and one history
// sample, adds its product to the passing sum. Depends on fir_pkg.
module fir_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic [fir_pkg::IDX_W-1:0]      cell_idx,
   input  fir_pkg::item_type              in_item,
   output fir_pkg::item_type              out_item
);
   import fir_pkg::*;

   logic signed [COEF_W-1:0]          coef_ff, coef_in;
   logic signed [SAMPLE_W-1:0]        hist_ff, hist_in;
   item_type                          out_ff, out_in;
   logic signed [SAMPLE_W-1:0]        smp;
   logic signed [SAMPLE_W+COEF_W-1:0] prod;
   logic signed [ACC_W-1:0]           acc;
   logic                              hit, sample_hit, load_hit;

   assign hit        = adv && in_item.vld;
   assign sample_hit = hit && (in_item.mode == MODE_SAMPLE);
   assign load_hit   = hit && (in_item.mode == MODE_COEF) && (in_item.idx == cell_idx);

   assign smp  = in_item.smp;
   assign acc  = in_item.acc;
   assign prod = smp * coef_ff;

   assign coef_in = load_hit ? in_item.coef : coef_ff;
   assign hist_in = sample_hit ? smp : hist_ff;

   always_comb begin
      out_in     = in_item;
      out_in.smp = in_item.blk ? '0 : hist_ff;
      out_in.acc = acc + ACC_W'(prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
         hist_ff <= '0;
      end else begin
         coef_ff <= coef_in;
         hist_ff <= hist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         out_ff <= out_in;
      end
   end

   assign out_item = out_ff;

`ifndef SYNTHESIS
   a_coef_only_on_load: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(coef_ff)) |-> $past(load_hit))
      else $error("coefficient changed without a load transaction");

   a_hist_only_on_sample: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(hist_ff)) |-> $past(sample_hit))
      else $error("history changed without a sample transaction");
`endif

endmodule

@@ hdl/fir_round.sv @@
// Output stage: rounds the chain sum, saturates to the sample width and
// holds the result until taken. Depends on fir_pkg.
module fir_round (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  logic signed [fir_pkg::ACC_W-1:0]  in_acc,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [fir_pkg::SAMPLE_W-1:0] rsp_filtered,
   output logic                              rsp_saturated
);
   import fir_pkg::*;

   logic                       valid_ff, valid_in;
   logic signed [SAMPLE_W-1:0] filt_ff, filt_in;
   logic                       sat_ff, sat_in;
   logic signed [ACC_W-1:0]    rounded, shifted;

   assign in_ready = !valid_ff || rsp_ready;

   assign rounded = in_acc + ROUND_HALF;
   assign shifted = rounded >>> FRAC_W;

   always_comb begin
      if (shifted > OUT_MAX) begin
         filt_in = SAMPLE_W'(OUT_MAX);
         sat_in  = 1'b1;
      end else if (shifted < OUT_MIN) begin
         filt_in = SAMPLE_W'(OUT_MIN);
         sat_in  = 1'b1;
      end else begin
         filt_in = SAMPLE_W'(shifted);
         sat_in  = 1'b0;
      end
   end

   assign valid_in = in_valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         filt_ff <= filt_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_filtered  = filt_ff;
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   a_sat_at_rail: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && sat_ff) |->
         (filt_ff == SAMPLE_W'(OUT_MAX) || filt_ff == SAMPLE_W'(OUT_MIN)))
      else $error("saturated result is not at a rail");
`endif

endmodule

@@ sim/tb.sv @@
// Testbench for fir_filter_32_tap: a directed table, then random transactions
// in three idle phases, checked against a behavioral filter model kept here.
// Depends on fir_pkg and fir_filter_32_tap.
`timescale 1ns / 1ps

module tb;
   import fir_pkg::*;

   localparam int N_DIRECTED = 20;
   localparam int N_RANDOM   = 950;
   localparam int LIMIT      = 200000;

   typedef struct packed {
      logic                       mode;
      logic                       blk;
      logic signed [SAMPLE_W-1:0] smp;
      logic [IDX_W-1:0]           idx;
      logic signed [COEF_W-1:0]   coef;
      logic                       typed;
      logic signed [SAMPLE_W-1:0] y;
      logic                       sat;
   } stim_row_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] filtered;
      logic                       saturated;
   } fir_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_mode = MODE_SAMPLE;
   logic                       req_block_start = 1'b0;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [IDX_W-1:0]           req_coef_index = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic                       rsp_saturated;

   logic signed [COEF_W-1:0]   tap_coef [TAPS];
   logic signed [SAMPLE_W-1:0] sample_hist [TAPS-1];
   fir_result_type             pending_outputs [$];
   int                         errors = 0;
   int                         cycles = 0;
   int                         send_idle = 6;
   int                         recv_idle = 77;

   stim_row_type directed_rows [N_DIRECTED] = '{
      '{MODE_SAMPLE, 1'b1,  16'sd32767,  5'd0,  18'sd0,       1'b1,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b0, -16'sd32768,  5'd31, -18'sd1,      1'b1,  16'sd0,     1'b0},
      '{MODE_COEF,   1'b1,  16'sd0,      5'd0,  18'sd131071,  1'b0,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b1,  16'sd32767,  5'd0,  18'sd0,       1'b1,  16'sd32767, 1'b1},
      '{MODE_SAMPLE, 1'b1, -16'sd32768,  5'd0,  18'sd0,       1'b1, -16'sd32768, 1'b1},
      '{MODE_COEF,   1'b0, -16'sd1,      5'd0, -18'sd131072,  1'b0,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b1, -16'sd32768,  5'd0,  18'sd0,       1'b1,  16'sd32767, 1'b1},
      '{MODE_SAMPLE, 1'b1,  16'sd32767,  5'd0,  18'sd0,       1'b1, -16'sd32768, 1'b1},
      '{MODE_COEF,   1'b0,  16'sd0,      5'd0,  18'sd65536,   1'b0,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b1,  16'sd1234,   5'd0,  18'sd0,       1'b1,  16'sd1234,  1'b0},
      '{MODE_SAMPLE, 1'b0, -16'sd5,      5'd0,  18'sd0,       1'b1, -16'sd5,     1'b0},
      '{MODE_COEF,   1'b0,  16'sd0,      5'd0,  18'sd32768,   1'b0,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b1,  16'sd1,      5'd0,  18'sd0,       1'b1,  16'sd1,     1'b0},
      '{MODE_SAMPLE, 1'b1, -16'sd1,      5'd0,  18'sd0,       1'b1,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b1,  16'sd3,      5'd0,  18'sd0,       1'b1,  16'sd2,     1'b0},
      '{MODE_COEF,   1'b0,  16'sd0,      5'd31, 18'sd65536,   1'b0,  16'sd0,     1'b0},
      '{MODE_COEF,   1'b0,  16'sd0,      5'd1, -18'sd65536,   1'b0,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b1,  16'sd1000,   5'd0,  18'sd0,       1'b1,  16'sd500,   1'b0},
      '{MODE_SAMPLE, 1'b0,  16'sd2000,   5'd0,  18'sd0,       1'b0,  16'sd0,     1'b0},
      '{MODE_SAMPLE, 1'b0, -16'sd32768,  5'd0,  18'sd0,       1'b0,  16'sd0,     1'b0}
   };

   fir_filter_32_tap u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_block_start (req_block_start),
      .req_sample      (req_sample),
      .req_coef_index  (req_coef_index),
      .req_coef_value  (req_coef_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered),
      .rsp_saturated   (rsp_saturated)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Golden filter: updates taps/history, returns the rounded, clipped output.
   task automatic run_filter(input logic mode, input logic blk,
                             input logic signed [SAMPLE_W-1:0] smp,
                             input logic [IDX_W-1:0] idx,
                             input logic signed [COEF_W-1:0] coef,
                             output fir_result_type res);
      longint acc;
      if (mode == MODE_COEF) begin
         tap_coef[idx] = coef;
         res = '0;
         return;
      end
      if (blk)
         foreach (sample_hist[j]) sample_hist[j] = '0;
      acc = longint'(smp) * longint'(tap_coef[0]);
      for (int j = 1; j < TAPS; j++)
         acc += longint'(sample_hist[j-1]) * longint'(tap_coef[j]);
      for (int j = TAPS - 2; j > 0; j--)
         sample_hist[j] = sample_hist[j-1];
      sample_hist[0] = smp;
      acc = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      res.saturated = 1'b1;
      if (acc > longint'(32767))
         res.filtered = 16'sh7fff;
      else if (acc < -longint'(32768))
         res.filtered = 16'sh8000;
      else begin
         res.filtered  = acc[SAMPLE_W-1:0];
         res.saturated = 1'b0;
      end
   endtask

   // Drives one transaction from the falling edge; returns at its acceptance edge.
   task automatic send_transaction(input stim_row_type row);
      fir_result_type res;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_mode        = row.mode;
      req_block_start = row.blk;
      req_sample      = row.smp;
      req_coef_index  = row.idx;
      req_coef_value  = row.coef;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      run_filter(row.mode, row.blk, row.smp, row.idx, row.coef, res);
      if (row.mode == MODE_SAMPLE) begin
         if (row.typed) begin
            res.filtered  = row.y;
            res.saturated = row.sat;
         end
         pending_outputs.push_back(res);
      end
   endtask

   function automatic int rand_value(input int w);
      int v;
      int r;
      r = 1 << (w / 2);
      case ($urandom_range(0, 5))
         0, 1:    v = $urandom;
         2:       v = (1 << (w - 1)) - 1;
         3:       v = -(1 << (w - 1));
         default: v = $urandom_range(0, 2 * r) - r;
      endcase
      return (v <<< (32 - w)) >>> (32 - w);
   endfunction

   always @(posedge clock) begin
      fir_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected result %0d", rsp_filtered));
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_filtered !== want.filtered)
               report_mismatch($sformatf("filtered %0d, want %0d",
                                         rsp_filtered, want.filtered));
            if (rsp_saturated !== want.saturated)
               report_mismatch($sformatf("saturated %b, want %b",
                                         rsp_saturated, want.saturated));
         end
      end
   end

   initial begin
      stim_row_type row;
      foreach (tap_coef[j]) tap_coef[j] = '0;
      foreach (sample_hist[j]) sample_hist[j] = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_transaction(directed_rows[i]);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 6 : (phase == 1) ? 77 : 0;
         recv_idle = (phase == 0) ? 77 : (phase == 1) ? 6 : 0;
         for (int n = 0; n < N_RANDOM / 3; n++) begin
            row.mode  = ($urandom_range(0, 99) < 12) ? MODE_COEF : MODE_SAMPLE;
            row.blk   = ($urandom_range(0, 99) < 4);
            row.smp   = SAMPLE_W'(rand_value(SAMPLE_W));
            row.idx   = IDX_W'($urandom);
            row.coef  = COEF_W'(rand_value(COEF_W));
            row.typed = 1'b0;
            row.y     = '0;
            row.sat   = 1'b0;
            send_transaction(row);
         end
      end
      @(negedge clock);
      req_valid = 1'b0;

      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule
